// File: src/v3dcn_pkg.sv
// Shared types and constants for the vector dot / cross / normalise unit.
// No dependencies.
package v3dcn_pkg;

    localparam int UNIT_SHIFT_DEF = 12;

    localparam logic [1:0] MODE_DOT   = 2'd0;
    localparam logic [1:0] MODE_CROSS = 2'd1;
    localparam logic [1:0] MODE_NORM  = 2'd2;

    typedef struct packed {
        logic        [1:0]  mode;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] res_x;
        logic signed [31:0] res_y;
        logic signed [31:0] res_z;
    } t_out;

endpackage

// File: src/vector3_dot_cross_normalize.sv
// Top level of the vector dot / cross / normalise unit, the whole pipeline. Depends on v3dcn_pkg.
// One beat per cycle while the output is not stalled.
// Stages: products, sums, one quotient bit per stage of |c|^2*2^(2U+2)/sumsq,
// one root bit per stage of the integer square root, output register.
// A stalled output freezes the whole pipeline. Reset clears all valid bits.
module vector3_dot_cross_normalize #(
    parameter int UNIT_SHIFT = v3dcn_pkg::UNIT_SHIFT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  v3dcn_pkg::t_in   i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output v3dcn_pkg::t_out  o_res
);

    localparam int DW = 2*UNIT_SHIFT + 3;
    localparam int SN = UNIT_SHIFT + 2;
    localparam int RW = UNIT_SHIFT + 5;
    localparam int NS = DW + SN;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  neg;
        logic        zero;
        logic [95:0] res;
    } t_side;

    logic adv;
    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;

    // stage 1: products and squares
    logic        r_v1;
    t_side       r_side1;
    logic [31:0] r_p1 [0:8];
    logic [63:0] r_sq1 [0:2];

    logic [31:0] in_c [0:2];
    logic [31:0] in_m [0:2];
    assign in_c[0] = i_data.a_x;
    assign in_c[1] = i_data.a_y;
    assign in_c[2] = i_data.a_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_m[i] = in_c[i][31] ? (32'd0 - in_c[i]) : in_c[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
        end
        if (adv) begin
            r_side1.mode <= i_data.mode;
            r_side1.neg  <= {in_c[2][31], in_c[1][31], in_c[0][31]};
            r_side1.zero <= 1'b0;
            r_side1.res  <= '0;
            r_p1[0] <= i_data.a_x * i_data.b_x;
            r_p1[1] <= i_data.a_y * i_data.b_y;
            r_p1[2] <= i_data.a_z * i_data.b_z;
            r_p1[3] <= i_data.a_y * i_data.b_z;
            r_p1[4] <= i_data.a_z * i_data.b_y;
            r_p1[5] <= i_data.a_z * i_data.b_x;
            r_p1[6] <= i_data.a_x * i_data.b_z;
            r_p1[7] <= i_data.a_x * i_data.b_y;
            r_p1[8] <= i_data.a_y * i_data.b_x;
            for (int i = 0; i < 3; i++) begin
                r_sq1[i] <= {32'd0, in_m[i]} * {32'd0, in_m[i]};
            end
        end
    end

    // pipeline arrays, index 0 = after sums, 1..DW divider, DW+1..NS sqrt
    logic             r_v    [0:NS];
    t_side            r_side [0:NS];
    logic [63:0]      r_s    [0:DW];
    logic [63:0]      r_rem  [0:DW][0:2];
    logic [DW-1:0]    r_q    [0:DW][0:2];
    logic [2:0]       r_bit;
    logic [DW:0]      r_sd   [DW+1:NS][0:2];
    logic [RW-1:0]    r_srem [DW+1:NS][0:2];
    logic [SN-1:0]    r_root [DW+1:NS][0:2];

    localparam logic [1:0] MODE_DOT_L   = v3dcn_pkg::MODE_DOT;
    localparam logic [1:0] MODE_CROSS_L = v3dcn_pkg::MODE_CROSS;

    // stage 2: sums
    logic [63:0] sumsq;
    t_side       side2;
    assign sumsq = r_sq1[0] + r_sq1[1] + r_sq1[2];

    always_comb begin
        side2 = r_side1;
        side2.zero = (sumsq == 64'd0);
        case (r_side1.mode)
            MODE_DOT_L: side2.res = {r_p1[0] + r_p1[1] + r_p1[2], 32'd0, 32'd0};
            MODE_CROSS_L: side2.res = {r_p1[3] - r_p1[4], r_p1[5] - r_p1[6],
                                       r_p1[7] - r_p1[8]};
            default: side2.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= r_v1;
        end
        if (adv) begin
            r_side[0] <= side2;
            r_s[0]    <= sumsq;
            for (int i = 0; i < 3; i++) begin
                r_rem[0][i] <= r_sq1[i] >> 1;
                r_q[0][i]   <= '0;
                r_bit[i]    <= r_sq1[i][0];
            end
        end
    end

    // restoring division, one quotient bit per stage
    genvar j, l;
    generate
        for (j = 0; j < DW; j++) begin : g_div
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[j+1] <= 1'b0;
                end else if (adv) begin
                    r_v[j+1] <= r_v[j];
                end
            end
            for (l = 0; l < 3; l++) begin : g_lane
                logic [64:0] t;
                logic        ge;
                assign t  = {r_rem[j][l], (j == 0) ? r_bit[l] : 1'b0};
                assign ge = (t >= {1'b0, r_s[j]});
                always_ff @(posedge i_clk) begin
                    if (adv) begin
                        r_rem[j+1][l] <= ge ? 64'(t - {1'b0, r_s[j]}) : t[63:0];
                        r_q[j+1][l]   <= {r_q[j][l][DW-2:0], ge};
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_side[j+1] <= r_side[j];
                    r_s[j+1]    <= r_s[j];
                end
            end
        end

        // integer square root, one root bit per stage
        for (j = DW; j < NS; j++) begin : g_sqrt
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[j+1] <= 1'b0;
                end else if (adv) begin
                    r_v[j+1] <= r_v[j];
                end
                if (adv) begin
                    r_side[j+1] <= r_side[j];
                end
            end
            for (l = 0; l < 3; l++) begin : g_lane
                logic [DW:0]     sd;
                logic [RW-1:0]   rem;
                logic [SN-1:0]   root;
                logic [RW-1:0]   t;
                logic [RW-1:0]   trial;
                logic            ge;
                if (j == DW) begin : g_first
                    assign sd   = {1'b0, r_q[DW][l]};
                    assign rem  = '0;
                    assign root = '0;
                end else begin : g_next
                    assign sd   = r_sd[j][l];
                    assign rem  = r_srem[j][l];
                    assign root = r_root[j][l];
                end
                assign t     = {rem[RW-3:0], sd[DW:DW-1]};
                assign trial = RW'({root, 2'b01});
                assign ge    = (t >= trial);
                always_ff @(posedge i_clk) begin
                    if (adv) begin
                        r_sd[j+1][l]   <= {sd[DW-2:0], 2'b00};
                        r_srem[j+1][l] <= ge ? (t - trial) : t;
                        r_root[j+1][l] <= {root[SN-2:0], ge};
                    end
                end
            end
        end
    endgenerate

    // output stage
    logic [SN:0]     k1   [0:2];
    logic [31:0]     mag  [0:2];
    logic [31:0]     comp [0:2];
    v3dcn_pkg::t_out n_res;
    v3dcn_pkg::t_out r_res;
    logic            r_ov;
    t_side           sl;
    assign sl = r_side[NS];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            k1[i]   = {1'b0, r_root[NS][i]} + (SN+1)'(1);
            mag[i]  = 32'(k1[i][SN:1]);
            comp[i] = sl.neg[i] ? (32'd0 - mag[i]) : mag[i];
        end
        if (sl.mode == v3dcn_pkg::MODE_NORM) begin
            if (sl.zero) begin
                n_res = {32'd0, 32'd0, 32'(1) << UNIT_SHIFT};
            end else begin
                n_res = {comp[0], comp[1], comp[2]};
            end
        end else begin
            n_res = sl.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_v[NS];
        end
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;

endmodule

// File: sim/v3dcn_checker.sv
`timescale 1ns / 1ps
// Checker for the vector dot / cross / normalise unit: watches both channels,
// predicts each result beat and compares it field by field. Depends on v3dcn_pkg.
module v3dcn_checker #(
    parameter int UNIT_SHIFT = v3dcn_pkg::UNIT_SHIFT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  v3dcn_pkg::t_in   i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  v3dcn_pkg::t_out  i_out_res,
    output int               o_fail_count,
    output int               o_pending
);

    v3dcn_pkg::t_out expected_res[$];

    // largest r in [0, 2^U] with (2r-1)^2 * sumsq <= (2 * mag * 2^U)^2
    function automatic logic [31:0] unit_mag(logic [63:0] mag, logic [63:0] sumsq);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [127:0] lo;
        logic [127:0] hi;
        logic [127:0] m;
        logic [127:0] odd;
        rhs = {64'd0, mag * mag} << (2 * UNIT_SHIFT + 2);
        lo = 0;
        hi = 128'd1 << UNIT_SHIFT;
        while (lo < hi) begin
            m = (lo + hi + 1) >> 1;
            odd = 2 * m - 1;
            lhs = (odd * odd) * {64'd0, sumsq};
            if (lhs <= rhs) lo = m;
            else hi = m - 1;
        end
        return lo[31:0];
    endfunction

    function automatic v3dcn_pkg::t_out vec_result(v3dcn_pkg::t_in d);
        logic signed [63:0] ax, ay, az, bx, by, bz, p;
        logic [63:0] mx, my, mz, sumsq;
        logic [31:0] q;
        v3dcn_pkg::t_out r;
        ax = d.a_x; ay = d.a_y; az = d.a_z;
        bx = d.b_x; by = d.b_y; bz = d.b_z;
        r = '0;
        case (d.mode)
            v3dcn_pkg::MODE_DOT: begin
                p = ax * bx + ay * by + az * bz;
                r.res_x = p[31:0];
            end
            v3dcn_pkg::MODE_CROSS: begin
                p = ay * bz - az * by; r.res_x = p[31:0];
                p = az * bx - ax * bz; r.res_y = p[31:0];
                p = ax * by - ay * bx; r.res_z = p[31:0];
            end
            v3dcn_pkg::MODE_NORM: begin
                mx = (ax < 0) ? -ax : ax;
                my = (ay < 0) ? -ay : ay;
                mz = (az < 0) ? -az : az;
                sumsq = mx * mx + my * my + mz * mz;
                if (sumsq == 0) begin
                    r.res_z = 32'sd1 <<< UNIT_SHIFT;
                end else begin
                    q = unit_mag(mx, sumsq); r.res_x = (ax < 0) ? -q : q;
                    q = unit_mag(my, sumsq); r.res_y = (ay < 0) ? -q : q;
                    q = unit_mag(mz, sumsq); r.res_z = (az < 0) ? -q : q;
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d, expected %0d", what, $signed(got), $signed(want));
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        v3dcn_pkg::t_out want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) expected_res.push_back(vec_result(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (expected_res.size() == 0) begin
                    $display("unexpected result beat");
                    o_fail_count++;
                end else begin
                    want = expected_res.pop_front();
                    if (i_out_res.res_x !== want.res_x)
                        report_mismatch("res_x", i_out_res.res_x, want.res_x);
                    if (i_out_res.res_y !== want.res_y)
                        report_mismatch("res_y", i_out_res.res_y, want.res_y);
                    if (i_out_res.res_z !== want.res_z)
                        report_mismatch("res_z", i_out_res.res_z, want.res_z);
                end
            end
        end
        o_pending = expected_res.size();
    end

endmodule

// File: sim/tb_vector3_dot_cross_normalize.sv
`timescale 1ns / 1ps
// Testbench top for vector3_dot_cross_normalize: directed and random beats with
// bursty input and random output stalls. Depends on v3dcn_pkg and v3dcn_checker.
module tb_vector3_dot_cross_normalize;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int N_RANDOM = 1250;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN = 2 * v3dcn_pkg::UNIT_SHIFT_DEF + 40;
    localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S_MIN = 32'sh80000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    v3dcn_pkg::t_in  i_data = '0;
    logic o_stall, o_valid;
    v3dcn_pkg::t_out o_res;
    int   fail_count, pending;
    int   cycle = 0;

    always #2 i_clk = ~i_clk;

    vector3_dot_cross_normalize i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_res(o_res)
    );

    v3dcn_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_in_data(i_data),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_out_res(o_res),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT) begin
            $display("tb_vector3_dot_cross_normalize failed");
            $finish;
        end
    end

    // receiver: stall density is redrawn from 0, 25, 50 or 75 percent; one long hold-off
    initial begin
        int pct;
        pct = 0;
        forever begin
            @(posedge i_clk);
            if (cycle == 600) begin
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
            end else begin
                if (cycle % 64 == 0) pct = $urandom_range(0, 3) * 25;
                i_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return S_MAX;
            1: return S_MIN;
            2: return $signed($urandom_range(0, 2000)) - 1000;
            3: return $signed($urandom_range(0, 8));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(logic [1:0] mode, logic signed [31:0] ax, ay, az, bx, by, bz);
        i_data <= '{mode, ax, ay, az, bx, by, bz};
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    initial begin
        int burst;
        logic [1:0] mode;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(v3dcn_pkg::MODE_DOT, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX);
        send_beat(v3dcn_pkg::MODE_DOT, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN);
        send_beat(v3dcn_pkg::MODE_DOT, S_MIN, S_MAX, -1, S_MAX, S_MIN, 1);
        send_beat(v3dcn_pkg::MODE_CROSS, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN);
        send_beat(v3dcn_pkg::MODE_CROSS, 1, 0, 0, 0, 1, 0);
        send_beat(v3dcn_pkg::MODE_CROSS, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX);
        send_beat(v3dcn_pkg::MODE_NORM, 0, 0, 0, 5, 6, 7);
        send_beat(v3dcn_pkg::MODE_NORM, 1, 0, 0, 0, 0, 0);
        send_beat(v3dcn_pkg::MODE_NORM, -5, 0, 0, 0, 0, 0);
        send_beat(v3dcn_pkg::MODE_NORM, 1, 1, 0, 0, 0, 0);
        send_beat(v3dcn_pkg::MODE_NORM, 1, 1, 1, 0, 0, 0);
        send_beat(v3dcn_pkg::MODE_NORM, -3, 4, 0, 0, 0, 0);
        send_beat(v3dcn_pkg::MODE_NORM, S_MIN, S_MIN, S_MIN, 0, 0, 0);
        send_beat(v3dcn_pkg::MODE_NORM, S_MAX, S_MAX, S_MAX, 0, 0, 0);
        send_beat(v3dcn_pkg::MODE_NORM, S_MIN, 0, 1, 0, 0, 0);
        send_beat(v3dcn_pkg::MODE_NORM, 0, 0, -1, 0, 0, 0);
        send_beat(v3dcn_pkg::MODE_NORM, S_MAX, 1, S_MIN, -1, -1, -1);
        send_beat(MODE_UNUSED, S_MAX, S_MIN, -1, 1, 2, 3);
        send_beat(MODE_UNUSED, 0, 0, 0, 0, 0, 0);
        idle_gap(3);

        burst = 0;
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM / 2) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                wait (pending == 0);
                @(posedge i_clk);
            end
            if (burst == 0) begin
                idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
                burst = $urandom_range(1, 40);
            end
            mode = ($urandom_range(0, 19) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
            send_beat(mode, rand_comp(), rand_comp(), rand_comp(),
                      rand_comp(), rand_comp(), rand_comp());
            burst--;
        end
        i_valid <= 1'b0;
        @(posedge i_clk);

        wait (pending == 0);
        repeat (DRAIN) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_vector3_dot_cross_normalize passed");
        end else begin
            $display("tb_vector3_dot_cross_normalize failed");
        end
        $finish;
    end

endmodule

// File: files.f
src/v3dcn_pkg.sv
src/vector3_dot_cross_normalize.sv
sim/v3dcn_checker.sv
sim/tb_vector3_dot_cross_normalize.sv
